// ----- design/pre_pkg.sv -----
// ----------------------------------------------------------------------------
// pre_pkg
// Shared constants and types of the printable run extractor.
// ----------------------------------------------------------------------------
package pre_pkg;

	localparam int MAX_MIN_LEN  = 62;
	localparam int HOLD_ADDR_W  = $clog2(MAX_MIN_LEN);
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);

	localparam logic [5:0] MIN_LEN_RESET = 6'd4;
	localparam logic [5:0] MIN_LEN_MAX   = 6'(MAX_MIN_LEN);
	localparam logic [7:0] GRAPHIC_LO    = 8'h21;
	localparam logic [7:0] GRAPHIC_HI    = 8'h7E;

	// work for the back end, one entry per accepted byte that emits anything
	typedef struct packed {
		logic [31:0] offset;
		logic [7:0]  data;
		logic [5:0]  flush_cnt;
		logic        do_flush;
		logic        do_byte;
		logic        do_end;
	} cmd_t;

	typedef struct packed {
		logic                   en;
		logic [HOLD_ADDR_W-1:0] addr;
		logic [7:0]             data;
	} hold_wr_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_FLUSH,
		B_BYTE,
		B_END
	} back_state_t;

endpackage

// ----- design/pre_ram.sv -----
// ----------------------------------------------------------------------------
// pre_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 62
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- design/pre_front.sv -----
// ----------------------------------------------------------------------------
// pre_front
// Accepts bytes, tracks the run state and offsets, stores held bytes and
// issues emit commands to the back end.
// ----------------------------------------------------------------------------
module pre_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              min_len_we,
	input  logic [5:0]        min_len_wdata,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        text_byte,
	input  logic              buffer_end,
	output pre_pkg::hold_wr_t hold_wr,
	output logic              cmd_push,
	output pre_pkg::cmd_t     cmd,
	input  logic              cmd_full,
	input  logic              flush_done
);
	import pre_pkg::*;

	logic [5:0]  min_len_q;
	logic [31:0] byte_off_q;
	logic [31:0] start_q;
	logic [5:0]  run_len_q;
	logic        pass_q;
	logic        flush_busy_q;

	logic        acc;
	logic        graphic;
	logic        start_new;
	logic        below;
	logic        do_flush;
	logic        do_byte;
	logic        do_end;
	logic        closing;
	logic [31:0] run_start;
	logic [5:0]  run_len_inc;

	always_comb begin
		graphic     = text_byte inside {[GRAPHIC_LO:GRAPHIC_HI]};
		full        = cmd_full || flush_busy_q;
		acc         = push && !full;
		start_new   = graphic && run_len_q == 6'd0 && !pass_q;
		run_start   = start_new ? byte_off_q : start_q;
		below       = run_len_q < min_len_q;
		do_flush    = graphic && !pass_q && !below;
		do_byte     = graphic && (pass_q || do_flush);
		closing     = !graphic || buffer_end;
		do_end      = closing && (pass_q || do_flush);
		run_len_inc = (run_len_q == 6'd63) ? run_len_q : run_len_q + 6'd1;

		hold_wr.en   = acc && graphic && !pass_q && below && run_len_q < MIN_LEN_MAX;
		hold_wr.addr = run_len_q[HOLD_ADDR_W-1:0];
		hold_wr.data = text_byte;

		cmd_push      = acc && (do_byte || do_end);
		cmd.offset    = run_start;
		cmd.data      = text_byte;
		cmd.flush_cnt = (run_len_q > MIN_LEN_MAX) ? MIN_LEN_MAX : run_len_q;
		cmd.do_flush  = do_flush;
		cmd.do_byte   = do_byte;
		cmd.do_end    = do_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q    <= MIN_LEN_RESET;
			byte_off_q   <= '0;
			start_q      <= '0;
			run_len_q    <= '0;
			pass_q       <= 1'b0;
			flush_busy_q <= 1'b0;
		end else begin
			if (min_len_we) begin
				min_len_q <= (min_len_wdata > MIN_LEN_MAX) ? MIN_LEN_MAX : min_len_wdata;
			end
			// held storage is reused by the next run, so wait for the readout
			if (flush_done) begin
				flush_busy_q <= 1'b0;
			end else if (acc && do_flush && cmd.flush_cnt != 6'd0) begin
				flush_busy_q <= 1'b1;
			end
			if (acc) begin
				start_q    <= run_start;
				byte_off_q <= buffer_end ? 32'd0 : byte_off_q + 32'd1;
				if (closing) begin
					run_len_q <= '0;
					pass_q    <= 1'b0;
				end else begin
					run_len_q <= run_len_inc;
					pass_q    <= pass_q || do_flush;
				end
			end
		end
	end

endmodule

// ----- design/pre_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// pre_cmd_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module pre_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pre_pkg::cmd_t wdata,
	output logic          full,
	input  logic          pop,
	output pre_pkg::cmd_t rdata,
	output logic          empty
);
	import pre_pkg::*;

	cmd_t                entries_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_PTR_W:0]   count_q;
	logic                  do_push;
	logic                  do_pop;

	always_comb begin
		full    = count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH);
		empty   = count_q == '0;
		do_push = push && !full;
		do_pop  = pop && !empty;
		rdata   = entries_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- design/pre_back.sv -----
// ----------------------------------------------------------------------------
// pre_back
// Carries out emit commands: reads back held bytes, passes bytes, closes
// runs, and keeps the output register.
// ----------------------------------------------------------------------------
module pre_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_empty,
	input  pre_pkg::cmd_t                   cmd,
	output logic                            cmd_pop,
	output logic                            rd_en,
	output logic [pre_pkg::HOLD_ADDR_W-1:0] rd_addr,
	input  logic [7:0]                      rd_data,
	output logic                            flush_done,
	output logic                            empty,
	input  logic                            pop,
	output logic [31:0]                     run_offset,
	output logic [7:0]                      out_byte,
	output logic                            byte_valid,
	output logic                            run_end
);
	import pre_pkg::*;

	back_state_t state_q, state_d;
	cmd_t        cmd_q;
	logic [5:0]  idx_q;
	logic [5:0]  idx_nxt;
	logic        out_valid_q;
	logic        out_ready;
	logic        load;
	logic [7:0]  load_byte;
	logic        load_valid;
	logic        load_end;

	always_comb begin
		out_ready  = !out_valid_q || pop;
		idx_nxt    = idx_q + 6'd1;
		state_d    = state_q;
		cmd_pop    = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = '0;
		flush_done = 1'b0;
		load       = 1'b0;
		load_byte  = cmd_q.data;
		load_valid = 1'b1;
		load_end   = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					if (cmd.do_flush && cmd.flush_cnt != 6'd0) begin
						rd_en   = 1'b1;
						state_d = B_FLUSH;
					end else if (cmd.do_byte) begin
						state_d = B_BYTE;
					end else begin
						state_d = B_END;
					end
				end
			end
			B_FLUSH: begin
				load_byte = rd_data;
				if (out_ready) begin
					load = 1'b1;
					if (idx_nxt == cmd_q.flush_cnt) begin
						flush_done = 1'b1;
						state_d    = B_BYTE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_nxt[HOLD_ADDR_W-1:0];
					end
				end
			end
			B_BYTE: begin
				if (out_ready) begin
					load    = 1'b1;
					state_d = cmd_q.do_end ? B_END : B_IDLE;
				end
			end
			B_END: begin
				load_byte  = 8'h00;
				load_valid = 1'b0;
				load_end   = 1'b1;
				if (out_ready) begin
					load    = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_pop) begin
				idx_q <= '0;
			end else if (state_q == B_FLUSH && load) begin
				idx_q <= idx_nxt;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (load) begin
			run_offset <= cmd_q.offset;
			out_byte   <= load_byte;
			byte_valid <= load_valid;
			run_end    <= load_end;
		end
	end

	assign empty = !out_valid_q;

endmodule

// ----- design/printable_run_extractor.sv -----
// ----------------------------------------------------------------------------
// printable_run_extractor
// Finds runs of graphic characters longer than min_len in a byte stream.
// ----------------------------------------------------------------------------
// Input channel: drive text_byte and buffer_end with push; a byte is taken
// at a clock edge with push high and full low. buffer_end marks the last
// byte of a buffer and restarts offsets at zero.
// Result channel: while empty is low the oldest result sits on run_offset,
// out_byte, byte_valid and run_end; pop takes it. A reported run gives its
// characters (byte_valid) and then one end marker (run_end).
// min_len is written with min_len_we; values above 62 saturate to 62. Write
// it only while no results are pending.
// A held byte is only written to the hold memory and issues no command. A
// passed byte goes through the command queue, then the back end's idle and
// byte states, into the output register; the back end works on one command
// at a time. A flush of n held bytes reads the hold memory one entry a cycle
// while the output register is not stalled; full stays high while it runs.
// An end marker takes the end state, straight after the byte state if any.
// When pop stays low the output register holds, the four-entry command
// queue fills and full rises; nothing is dropped.
// Reset clears run state, offsets and queues and sets min_len to 4.
// ----------------------------------------------------------------------------
module printable_run_extractor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        min_len_we,
	input  logic [5:0]  min_len_wdata,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  text_byte,
	input  logic        buffer_end,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] run_offset,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        run_end
);
	import pre_pkg::*;

	hold_wr_t               hold_wr;
	logic                   cmd_push;
	cmd_t                   cmd_in;
	logic                   cmd_full;
	logic                   cmd_pop;
	cmd_t                   cmd_out;
	logic                   cmd_empty;
	logic                   rd_en;
	logic [HOLD_ADDR_W-1:0] rd_addr;
	logic [7:0]             rd_data;
	logic                   flush_done;

	pre_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.min_len_we    (min_len_we),
		.min_len_wdata (min_len_wdata),
		.push          (push),
		.full          (full),
		.text_byte     (text_byte),
		.buffer_end    (buffer_end),
		.hold_wr       (hold_wr),
		.cmd_push      (cmd_push),
		.cmd           (cmd_in),
		.cmd_full      (cmd_full),
		.flush_done    (flush_done)
	);

	pre_ram #(
		.WIDTH (8),
		.DEPTH (MAX_MIN_LEN)
	) u_hold (
		.clk     (clk),
		.wr_en   (hold_wr.en),
		.wr_addr (hold_wr.addr),
		.wr_data (hold_wr.data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pre_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	pre_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_empty  (cmd_empty),
		.cmd        (cmd_out),
		.cmd_pop    (cmd_pop),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.flush_done (flush_done),
		.empty      (empty),
		.pop        (pop),
		.run_offset (run_offset),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_end    (run_end)
	);

endmodule

// ----- design/pre_checker.sv -----
// ----------------------------------------------------------------------------
// pre_checker
// Port-level checks on the result channel of the printable run extractor.
// ----------------------------------------------------------------------------
module pre_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [31:0] run_offset,
	input logic [7:0]  out_byte,
	input logic        byte_valid,
	input logic        run_end
);

	// nothing is offered while reset is applied
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result offered during reset");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(run_offset) && $stable(out_byte)
			&& $stable(byte_valid) && $stable(run_end))
		else $error("stalled result changed");

	// every result is either a character or an end marker with a zero byte
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (byte_valid != run_end) && (!run_end || out_byte == 8'h00))
		else $error("malformed result");

	// a character is always followed by more of the same run
	a_same_run: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && byte_valid |=> empty || run_offset == $past(run_offset))
		else $error("run changed without end marker");

endmodule

bind printable_run_extractor pre_checker u_pre_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.run_offset (run_offset),
	.out_byte   (out_byte),
	.byte_valid (byte_valid),
	.run_end    (run_end)
);
